>>> hw/rtl/tsfm_pkg.sv
`timescale 1ns / 1ps
package tsfm_pkg;

	localparam int DEF_VERTEX_COUNT = 32;
	localparam int ROWS             = 32;
	localparam int ROW_W            = 32;
	localparam int VW               = 5;
	localparam int IDX_W            = 6;
	localparam int OP_W             = 3;
	localparam int CFG_W            = 6;
	localparam int DEG_W            = 6;
	localparam int CNT_W            = 10;
	localparam int ACC_W            = 11;
	localparam logic [CFG_W-1:0] PREFIX_RESET = 6'd10;

	localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
	localparam logic [OP_W-1:0] OP_REBUILD = 3'd3;
	localparam logic [OP_W-1:0] OP_REFRESH = 3'd4;
	localparam logic [OP_W-1:0] OP_READ    = 3'd5;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EDGE_A,
		ST_EDGE_B,
		ST_CUT_A,
		ST_CUT_B,
		ST_DIAG,
		ST_ROW,
		ST_SCAN,
		ST_RD_I,
		ST_RD_J,
		ST_SQ,
		ST_WR_I,
		ST_WR_J,
		ST_COUNT,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_TAKE,
		DP_WRITE,
		DP_RD_I,
		DP_RD_J,
		DP_SQ,
		DP_SNAP,
		DP_CNT,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t          op;
		logic [VW-1:0]   addr;
		logic [VW-1:0]   bitv;
		logic [VW-1:0]   vj;
		logic            load;
		logic            adj_set;
		logic            adj_clr;
		logic            mask_clr;
		logic            cnt_first;
		logic            err;
	} cmd_t;

	typedef struct packed {
		logic adjbit;
		logic forb;
		logic snap_bit;
		logic out_busy;
	} stat_t;

	function automatic logic [DEG_W-1:0] pop32(input logic [ROW_W-1:0] x);
		logic [DEG_W-1:0] c;
		c = '0;
		for (int n = 0; n < ROW_W; n++) begin
			c = c + DEG_W'(x[n]);
		end
		return c;
	endfunction

	// Vertex v sits at bit (nv - 1 - v), so vertex 0 is the top vertex bit.
	function automatic logic [ROW_W-1:0] vbit(input logic [VW-1:0] v, input logic [IDX_W-1:0] nv);
		return ROW_W'(1) << (nv - IDX_W'(1) - {1'b0, v});
	endfunction

endpackage

>>> hw/rtl/tsfm_req_if.sv
`timescale 1ns / 1ps
interface tsfm_req_if;
	import tsfm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      operation;
	logic [IDX_W-1:0]     first_vertex;
	logic [IDX_W-1:0]     second_vertex;
	logic [ROW_W-1:0]     row_adjacency;
	logic [ROW_W-1:0]     row_mask;

	modport source(output valid, operation, first_vertex, second_vertex, row_adjacency,
		row_mask, input ready);
	modport sink(input valid, operation, first_vertex, second_vertex, row_adjacency,
		row_mask, output ready);
endinterface

>>> hw/rtl/tsfm_rsp_if.sv
`timescale 1ns / 1ps
interface tsfm_rsp_if;
	import tsfm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ROW_W-1:0]     adjacency_out;
	logic [ROW_W-1:0]     mask_out;
	logic [DEG_W-1:0]     vertex_degree;
	logic [CNT_W-1:0]     edge_count;
	logic [CNT_W-1:0]     candidate_count;
	logic                 index_error;

	modport source(output valid, adjacency_out, mask_out, vertex_degree, edge_count,
		candidate_count, index_error, input ready);
	modport sink(input valid, adjacency_out, mask_out, vertex_degree, edge_count,
		candidate_count, index_error, output ready);
endinterface

>>> hw/rtl/tsfm_dp.sv
`timescale 1ns / 1ps
module tsfm_dp #(
	parameter int VERTEX_COUNT = tsfm_pkg::DEF_VERTEX_COUNT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tsfm_pkg::cmd_t             cmd,
	output tsfm_pkg::stat_t            stat,
	input  logic [tsfm_pkg::ROW_W-1:0] row_adjacency,
	input  logic [tsfm_pkg::ROW_W-1:0] row_mask,
	tsfm_rsp_if.source                 rsp
);
	import tsfm_pkg::*;

	localparam int NV = (VERTEX_COUNT < ROWS) ? VERTEX_COUNT : ROWS;
	localparam logic [IDX_W-1:0] NV6 = IDX_W'(NV);

	logic [ROW_W-1:0] adj_q  [ROWS];
	logic [ROW_W-1:0] mask_q [ROWS];
	logic [ROW_W-1:0] load_adj_q, load_mask_q;
	logic [ROW_W-1:0] ri_q, v_q, snap_q;
	logic             adjbit_q, forb_q;
	logic [ACC_W-1:0] ecnt_q, ccnt_q;
	logic             out_valid_q;
	logic [ROW_W-1:0] out_adj_q, out_mask_q;
	logic [DEG_W-1:0] out_deg_q;
	logic [CNT_W-1:0] out_ecnt_q, out_ccnt_q;
	logic             out_err_q;

	logic [ROW_W-1:0] rd_adj, rd_mask, bit_sel, adj_new, mask_new, rj;
	logic             square_hit;

	always_comb begin
		rd_adj   = adj_q[cmd.addr];
		rd_mask  = mask_q[cmd.addr];
		bit_sel  = vbit(cmd.bitv, NV6);
		adj_new  = cmd.load ? load_adj_q :
			((rd_adj | (cmd.adj_set ? bit_sel : '0)) & ~(cmd.adj_clr ? bit_sel : '0));
		mask_new = cmd.load ? load_mask_q : (rd_mask & ~(cmd.mask_clr ? bit_sel : '0));
		rj       = rd_adj | bit_sel;
		// Vertex k closes a square through j when it is not j, not a neighbor of j,
		// and shares at least two neighbors with j.
		square_hit = (cmd.addr != cmd.vj) && ((v_q & bit_sel) == '0) &&
			(pop32(rd_adj & v_q) > DEG_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				adj_q[r]  <= '0;
				mask_q[r] <= '1;
			end
		end else if (cmd.op == DP_WRITE) begin
			adj_q[cmd.addr]  <= adj_new;
			mask_q[cmd.addr] <= mask_new;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_TAKE: begin
				load_adj_q  <= row_adjacency;
				load_mask_q <= row_mask;
			end
			DP_RD_I: begin
				ri_q     <= rd_adj | bit_sel;
				adjbit_q <= (rd_adj & bit_sel) != '0;
				forb_q   <= 1'b0;
			end
			DP_RD_J: begin
				v_q    <= rj;
				forb_q <= (ri_q & rj) != '0;
			end
			DP_SQ: begin
				if (square_hit) begin
					forb_q <= 1'b1;
				end
			end
			DP_SNAP: begin
				snap_q <= rd_mask;
			end
			DP_CNT: begin
				ecnt_q <= (cmd.cnt_first ? '0 : ecnt_q) + ACC_W'(pop32(rd_adj));
				ccnt_q <= (cmd.cnt_first ? '0 : ccnt_q) + ACC_W'(pop32(rd_mask));
			end
			DP_OUT: begin
				out_adj_q  <= cmd.err ? '0 : rd_adj;
				out_mask_q <= cmd.err ? '0 : rd_mask;
				out_deg_q  <= cmd.err ? '0 : pop32(rd_adj);
				out_ecnt_q <= ecnt_q[ACC_W-1:1];
				out_ccnt_q <= ccnt_q[ACC_W-1:1];
				out_err_q  <= cmd.err;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == DP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.adjbit   = adjbit_q;
	assign stat.forb     = forb_q;
	assign stat.snap_bit = (snap_q & bit_sel) != '0;
	assign stat.out_busy = out_valid_q && !rsp.ready;

	assign rsp.valid           = out_valid_q;
	assign rsp.adjacency_out   = out_adj_q;
	assign rsp.mask_out        = out_mask_q;
	assign rsp.vertex_degree   = out_deg_q;
	assign rsp.edge_count      = out_ecnt_q;
	assign rsp.candidate_count = out_ccnt_q;
	assign rsp.index_error     = out_err_q;

endmodule

>>> hw/rtl/tsfm_ctrl.sv
`timescale 1ns / 1ps
module tsfm_ctrl #(
	parameter int VERTEX_COUNT = tsfm_pkg::DEF_VERTEX_COUNT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tsfm_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [tsfm_pkg::OP_W-1:0]  operation,
	input  logic [tsfm_pkg::IDX_W-1:0] first_vertex,
	input  logic [tsfm_pkg::IDX_W-1:0] second_vertex,
	output tsfm_pkg::cmd_t             cmd,
	input  tsfm_pkg::stat_t            stat
);
	import tsfm_pkg::*;

	localparam int NV = (VERTEX_COUNT < ROWS) ? VERTEX_COUNT : ROWS;
	localparam logic [IDX_W-1:0] NV6 = IDX_W'(NV);
	localparam logic [VW-1:0] NV1 = VW'(NV - 1);
	localparam logic [VW-1:0] NV2 = VW'(NV - 2);

	state_t           state_q, state_d;
	logic [CFG_W-1:0] prefix_q;
	logic [OP_W-1:0]  op_q;
	logic [IDX_W-1:0] a_q, b_q;
	logic             err_q, trial_q;
	logic [VW-1:0]    i_q, j_q, k_q;

	logic accept, err_in, pair_in, rebuild, kill;

	assign accept  = req_valid && req_ready;
	assign pair_in = (operation == OP_ADD) || (operation == OP_REMOVE) ||
		(operation == OP_REFRESH);
	assign err_in  = (first_vertex >= NV6) || (pair_in && (second_vertex >= NV6));
	assign rebuild = (op_q == OP_REBUILD);
	assign kill    = (rebuild && ({1'b0, i_q} < prefix_q)) || !trial_q || stat.forb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= PREFIX_RESET;
		end else if (cfg_we) begin
			prefix_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_READ;
			a_q     <= '0;
			b_q     <= '0;
			err_q   <= 1'b0;
			trial_q <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q  <= operation;
						a_q   <= first_vertex;
						b_q   <= second_vertex;
						err_q <= err_in;
						i_q   <= '0;
					end
				end
				ST_DIAG: begin
					if (i_q == NV1) begin
						i_q <= '0;
						j_q <= VW'(1);
					end else begin
						i_q <= i_q + VW'(1);
					end
				end
				ST_CUT_B: i_q <= '0;
				ST_ROW:   j_q <= i_q;
				ST_SCAN: begin
					if (!stat.snap_bit) begin
						if (j_q == NV1) begin
							if (i_q != NV1) begin
								i_q <= i_q + VW'(1);
							end
						end else begin
							j_q <= j_q + VW'(1);
						end
					end
				end
				ST_RD_J: trial_q <= !(rebuild && stat.adjbit);
				ST_SQ: begin
					if (stat.forb || (k_q == NV1)) begin
						k_q <= '0;
					end else begin
						k_q <= k_q + VW'(1);
					end
				end
				ST_WR_J: begin
					if (j_q == NV1) begin
						if (rebuild && (i_q != NV2)) begin
							i_q <= i_q + VW'(1);
							j_q <= i_q + VW'(2);
						end else if (!rebuild && (i_q != NV1)) begin
							i_q <= i_q + VW'(1);
						end
					end else begin
						j_q <= j_q + VW'(1);
					end
				end
				ST_COUNT: k_q <= (k_q == NV1) ? '0 : k_q + VW'(1);
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (err_in) begin
						state_d = ST_COUNT;
					end else begin
						case (operation)
							OP_LOAD:    state_d = ST_LOAD;
							OP_ADD:     state_d = ST_EDGE_A;
							OP_REMOVE:  state_d = ST_EDGE_A;
							OP_REBUILD: state_d = ST_DIAG;
							OP_REFRESH: state_d = ST_CUT_A;
							default:    state_d = ST_COUNT;
						endcase
					end
				end
			end
			ST_LOAD:   state_d = ST_COUNT;
			ST_EDGE_A: state_d = ST_EDGE_B;
			ST_EDGE_B: state_d = ST_COUNT;
			ST_CUT_A:  state_d = ST_CUT_B;
			ST_CUT_B:  state_d = ST_ROW;
			ST_DIAG:   state_d = (i_q == NV1) ? ST_RD_I : ST_DIAG;
			ST_ROW:    state_d = ST_SCAN;
			ST_SCAN: begin
				if (stat.snap_bit) begin
					state_d = ST_RD_I;
				end else if (j_q == NV1) begin
					state_d = (i_q == NV1) ? ST_COUNT : ST_ROW;
				end
			end
			ST_RD_I: state_d = ST_RD_J;
			ST_RD_J: state_d = (rebuild && stat.adjbit) ? ST_WR_I : ST_SQ;
			ST_SQ:   state_d = (stat.forb || (k_q == NV1)) ? ST_WR_I : ST_SQ;
			ST_WR_I: state_d = ST_WR_J;
			ST_WR_J: begin
				if (rebuild) begin
					state_d = ((j_q == NV1) && (i_q == NV2)) ? ST_COUNT : ST_RD_I;
				end else if (j_q == NV1) begin
					state_d = (i_q == NV1) ? ST_COUNT : ST_ROW;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_COUNT: state_d = (k_q == NV1) ? ST_OUT : ST_COUNT;
			ST_OUT:   state_d = stat.out_busy ? ST_OUT : ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.op    = DP_NOP;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.op    = DP_TAKE;
			end
			ST_LOAD: begin
				cmd.op   = DP_WRITE;
				cmd.addr = a_q[VW-1:0];
				cmd.load = 1'b1;
			end
			ST_EDGE_A, ST_EDGE_B: begin
				cmd.op      = DP_WRITE;
				cmd.addr    = (state_q == ST_EDGE_A) ? a_q[VW-1:0] : b_q[VW-1:0];
				cmd.bitv    = (state_q == ST_EDGE_A) ? b_q[VW-1:0] : a_q[VW-1:0];
				cmd.adj_set = (op_q == OP_ADD);
				cmd.adj_clr = (op_q == OP_REMOVE);
			end
			ST_CUT_A, ST_CUT_B: begin
				cmd.op       = DP_WRITE;
				cmd.addr     = (state_q == ST_CUT_A) ? a_q[VW-1:0] : b_q[VW-1:0];
				cmd.bitv     = (state_q == ST_CUT_A) ? b_q[VW-1:0] : a_q[VW-1:0];
				cmd.mask_clr = 1'b1;
			end
			ST_DIAG: begin
				cmd.op       = DP_WRITE;
				cmd.addr     = i_q;
				cmd.bitv     = i_q;
				cmd.mask_clr = 1'b1;
			end
			ST_ROW: begin
				cmd.op   = DP_SNAP;
				cmd.addr = i_q;
			end
			ST_SCAN: cmd.bitv = j_q;
			ST_RD_I: begin
				cmd.op   = DP_RD_I;
				cmd.addr = i_q;
				cmd.bitv = j_q;
			end
			ST_RD_J: begin
				cmd.op   = DP_RD_J;
				cmd.addr = j_q;
				cmd.bitv = i_q;
			end
			ST_SQ: begin
				cmd.op   = DP_SQ;
				cmd.addr = k_q;
				cmd.bitv = k_q;
				cmd.vj   = j_q;
			end
			ST_WR_I, ST_WR_J: begin
				// The trial edge comes out again and the pair leaves the mask when killed.
				cmd.op       = DP_WRITE;
				cmd.addr     = (state_q == ST_WR_I) ? i_q : j_q;
				cmd.bitv     = (state_q == ST_WR_I) ? j_q : i_q;
				cmd.adj_clr  = trial_q;
				cmd.mask_clr = kill;
			end
			ST_COUNT: begin
				cmd.op        = DP_CNT;
				cmd.addr      = k_q;
				cmd.cnt_first = (k_q == '0);
			end
			ST_OUT: begin
				cmd.op   = stat.out_busy ? DP_NOP : DP_OUT;
				cmd.addr = a_q[VW-1:0];
				cmd.err  = err_q;
			end
			default: begin
			end
		endcase
	end

	a_err_to_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && accept && err_in) |=> (state_q == ST_COUNT))
		else $error("bad index did not go straight to the count pass");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, i_q} < NV6) && ({1'b0, j_q} < NV6) && ({1'b0, k_q} < NV6))
		else $error("vertex counter out of range");

	a_rebuild_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_I && rebuild) |-> (i_q < j_q))
		else $error("rebuild pair not ordered");

	a_refresh_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_I && !rebuild) |-> (i_q <= j_q))
		else $error("refresh pair not ordered");

	a_k_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SQ && state_q != ST_COUNT) |-> (k_q == '0))
		else $error("scan counter not parked at zero");

endmodule

>>> hw/rtl/triangle_square_free_edge_mask_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake     Payload
// cfg      in   cfg_we        cfg_wdata (fixed prefix vertex count)
// req      in   valid/ready   operation, first_vertex, second_vertex, row_adjacency, row_mask
// rsp      out  valid/ready   adjacency_out, mask_out, vertex_degree, counts, index_error
//
// One command at a time over a single row port; N = min(VERTEX_COUNT, 32). Read goes straight to
// the count pass; load writes one row, add or remove two. All end with a count over N rows and output.
// Rebuild clears the diagonal mask bits, then tries every pair i < j; refresh cuts the pair from both
// masks, then tries each pair left in the mask: two row reads, at most an N-row square scan, two writes.
// arst_n clears the adjacency rows, sets every mask bit and loads a prefix of 10.
// The result sits in an output register, so a stalled rsp holds only the final step.
module triangle_square_free_edge_mask_top #(
	parameter int VERTEX_COUNT = tsfm_pkg::DEF_VERTEX_COUNT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tsfm_pkg::CFG_W-1:0] cfg_wdata,
	tsfm_req_if.sink                   req,
	tsfm_rsp_if.source                 rsp
);
	import tsfm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	tsfm_ctrl #(
		.VERTEX_COUNT(VERTEX_COUNT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_valid    (req.valid),
		.req_ready    (req.ready),
		.operation    (req.operation),
		.first_vertex (req.first_vertex),
		.second_vertex(req.second_vertex),
		.cmd          (cmd),
		.stat         (stat)
	);

	tsfm_dp #(
		.VERTEX_COUNT(VERTEX_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.row_adjacency(req.row_adjacency),
		.row_mask     (req.row_mask),
		.rsp          (rsp)
	);

endmodule

>>> tb/triangle_square_free_edge_mask_top_tb.sv
`timescale 1ns / 1ps
module triangle_square_free_edge_mask_top_tb;
	import tsfm_pkg::*;

	localparam int NV = 32;
	localparam int STALL_LIMIT = 400000;
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	typedef struct {
		logic [ROW_W-1:0] adj;
		logic [ROW_W-1:0] msk;
		logic [DEG_W-1:0] deg;
		logic [CNT_W-1:0] edges;
		logic [CNT_W-1:0] cands;
		logic             err;
	} graph_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	tsfm_req_if req ();
	tsfm_rsp_if rsp ();

	triangle_square_free_edge_mask_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.rsp      (rsp)
	);

	// Shadow graph state.
	logic [ROW_W-1:0] adj_rows[NV];
	logic [ROW_W-1:0] cand_rows[NV];
	logic [CFG_W-1:0] prefix_shadow;

	graph_result_t pending_results[$];
	int            mismatches;
	int            idle_cycles;
	int            burst_left;
	int            stall_mode;
	int            hold_left;
	bit            hold_request;
	int            cycle_no;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [ROW_W-1:0] vertex_bit(input int v);
		return ROW_W'(1) << (NV - 1 - v);
	endfunction

	function automatic bit closes_square(input int j);
		logic [ROW_W-1:0] v;
		v = adj_rows[j];
		for (int k = 0; k < NV; k++) begin
			if (k != j && (vertex_bit(k) & v) == '0 && $countones(adj_rows[k] & v) > 1)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic drop_candidate(input int a, input int b);
		cand_rows[a] &= ~vertex_bit(b);
		cand_rows[b] &= ~vertex_bit(a);
	endtask

	task automatic trial_edge(input int i, input int j);
		adj_rows[i] |= vertex_bit(j);
		adj_rows[j] |= vertex_bit(i);
		if ((adj_rows[i] & adj_rows[j]) != '0 || closes_square(j))
			drop_candidate(i, j);
		adj_rows[i] &= ~vertex_bit(j);
		adj_rows[j] &= ~vertex_bit(i);
	endtask

	task automatic predict_graph(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b, input logic [ROW_W-1:0] ra, input logic [ROW_W-1:0] rm);
		graph_result_t r;
		bit pair_op;
		int ecnt;
		int ccnt;
		logic [ROW_W-1:0] row;
		pair_op = (op == OP_ADD || op == OP_REMOVE || op == OP_REFRESH);
		r.err = (a >= NV) || (pair_op && b >= NV);
		ecnt = 0;
		ccnt = 0;
		if (!r.err) begin
			case (op)
				OP_LOAD: begin
					adj_rows[a] = ra;
					cand_rows[a] = rm;
				end
				OP_ADD: begin
					adj_rows[a] |= vertex_bit(b);
					adj_rows[b] |= vertex_bit(a);
				end
				OP_REMOVE: begin
					adj_rows[a] &= ~vertex_bit(b);
					adj_rows[b] &= ~vertex_bit(a);
				end
				OP_REBUILD: begin
					for (int i = 0; i < NV; i++) cand_rows[i] &= ~vertex_bit(i);
					for (int i = 0; i < NV; i++) begin
						for (int j = i + 1; j < NV; j++) begin
							if (i < prefix_shadow) drop_candidate(i, j);
							if ((adj_rows[i] & vertex_bit(j)) != '0) drop_candidate(i, j);
							else trial_edge(i, j);
						end
					end
				end
				OP_REFRESH: begin
					drop_candidate(a, b);
					for (int i = 0; i < NV; i++) begin
						row = cand_rows[i];
						for (int j = i; j < NV; j++)
							if ((row & vertex_bit(j)) != '0) trial_edge(i, j);
					end
				end
				default: ;
			endcase
		end
		for (int i = 0; i < NV; i++) begin
			ecnt += $countones(adj_rows[i]);
			ccnt += $countones(cand_rows[i]);
		end
		if (r.err) begin
			r.adj = '0;
			r.msk = '0;
			r.deg = '0;
		end else begin
			r.adj = adj_rows[a];
			r.msk = cand_rows[a];
			r.deg = DEG_W'($countones(adj_rows[a]));
		end
		r.edges = CNT_W'(ecnt >> 1);
		r.cands = CNT_W'(ccnt >> 1);
		pending_results.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Receiver: stall pattern plus an optional long hold-off.
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_request && hold_left == 0) begin
			hold_left <= 400;
			hold_request <= 1'b0;
			rsp.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(0, 3) != 0);
				default: rsp.ready <= (cycle_no % 7) < 3;
			endcase
		end
	end

	// Result checker and watchdog.
	always @(posedge clk) begin
		graph_result_t e;
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL triangle_square_free_edge_mask_top");
				$finish;
			end
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					$display("unexpected result transfer at %0t", $realtime);
					mismatches++;
				end else begin
					e = pending_results.pop_front();
					if (rsp.adjacency_out !== e.adj)
						report_mismatch("adjacency_out", rsp.adjacency_out, e.adj);
					if (rsp.mask_out !== e.msk)
						report_mismatch("mask_out", rsp.mask_out, e.msk);
					if (rsp.vertex_degree !== e.deg)
						report_mismatch("vertex_degree", 32'(rsp.vertex_degree), 32'(e.deg));
					if (rsp.edge_count !== e.edges)
						report_mismatch("edge_count", 32'(rsp.edge_count), 32'(e.edges));
					if (rsp.candidate_count !== e.cands)
						report_mismatch("candidate_count", 32'(rsp.candidate_count),
							32'(e.cands));
					if (rsp.index_error !== e.err)
						report_mismatch("index_error", 32'(rsp.index_error), 32'(e.err));
				end
			end
		end
	end

	task automatic send_command(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b, input logic [ROW_W-1:0] ra, input logic [ROW_W-1:0] rm);
		req.valid <= 1'b1;
		req.operation <= op;
		req.first_vertex <= a;
		req.second_vertex <= b;
		req.row_adjacency <= ra;
		req.row_mask <= rm;
		do @(posedge clk); while (!req.ready);
		predict_graph(op, a, b, ra, rm);
		burst_left--;
		if (burst_left <= 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 10);
		end
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_prefix(input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		prefix_shadow = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [ROW_W-1:0] sparse_row();
		return $urandom() & $urandom() & $urandom() & $urandom();
	endfunction

	task automatic test_directed();
		send_command(OP_READ, 0, 0, '0, '0);
		send_command(OP_READ, 31, 0, '0, '0);
		send_command(OP_READ, 32, 0, '0, '0);
		send_command(OP_ADD, 3, 63, '0, '0);
		send_command(OP_REFRESH, 63, 1, '0, '0);
		send_command(OP_LOAD, 63, 0, '1, '1);
		send_command(OP_ADD, 0, 1, '0, '0);
		send_command(OP_ADD, 1, 2, '0, '0);
		send_command(OP_ADD, 31, 30, '0, '0);
		// Diagonal bit through a self pair.
		send_command(OP_ADD, 5, 5, '0, '0);
		send_command(OP_REMOVE, 5, 5, '0, '0);
		send_command(OP_ADD, 7, 7, '0, '0);
		send_command(OP_REMOVE, 1, 2, '0, '0);
		send_command(OP_SPARE_6, 0, 0, '0, '0);
		send_command(OP_SPARE_7, 31, 0, '0, '0);
		send_command(OP_REBUILD, 0, 0, '0, '0);
		send_command(OP_REFRESH, 4, 4, '0, '0);
		// An asymmetric row with all 32 bits set.
		send_command(OP_LOAD, 31, 0, '1, '1);
		send_command(OP_LOAD, 12, 0, '0, '0);
		send_command(OP_REFRESH, 20, 21, '0, '0);
		send_command(OP_LOAD, 31, 0, '0, '1);
		send_command(OP_READ, 31, 0, '0, '0);
	endtask

	task automatic test_prefix_extremes();
		set_prefix(6'd0);
		send_command(OP_REBUILD, 2, 0, '0, '0);
		set_prefix(6'd32);
		send_command(OP_LOAD, 9, 0, sparse_row(), '1);
		send_command(OP_REBUILD, 9, 0, '0, '0);
		set_prefix(6'd63);
		send_command(OP_LOAD, 0, 0, '0, '1);
		send_command(OP_REBUILD, 0, 0, '0, '0);
		set_prefix(6'd10);
	endtask

	task automatic random_command();
		int pick;
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		pick = $urandom_range(0, 99);
		a = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom()) : IDX_W'($urandom_range(0, 31));
		b = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom()) : IDX_W'($urandom_range(0, 31));
		if (pick < 12)
			send_command(OP_LOAD, a, b, $urandom(), $urandom());
		else if (pick < 25)
			send_command(OP_LOAD, a, b, sparse_row(), ~sparse_row());
		else if (pick < 50)
			send_command(OP_ADD, a, b, $urandom(), $urandom());
		else if (pick < 63)
			send_command(OP_REMOVE, a, b, $urandom(), $urandom());
		else if (pick < 65)
			send_command(OP_REBUILD, a, b, $urandom(), $urandom());
		else if (pick < 67)
			send_command(OP_REFRESH, a, b, $urandom(), $urandom());
		else if (pick < 69)
			send_command(($urandom_range(0, 1) != 0) ? OP_SPARE_6 : OP_SPARE_7, a, b,
				$urandom(), $urandom());
		else
			send_command(OP_READ, a, b, $urandom(), $urandom());
	endtask

	task automatic test_random_mix();
		for (int n = 0; n < 180; n++) random_command();
	endtask

	// Sparse graph grown by edges, then a rebuild and a refresh, in four rounds.
	task automatic test_sparse_search();
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		for (int r = 0; r < 4; r++) begin
			for (int v = 0; v < 32; v += 8) send_command(OP_LOAD, v, 0, '0, '1);
			for (int n = 0; n < 30; n++) begin
				a = $urandom_range(0, 31);
				b = $urandom_range(0, 31);
				if (n % 7 == 6) send_command(OP_REMOVE, a, b, '0, '0);
				else send_command(OP_ADD, a, b, '0, '0);
			end
			send_command(OP_REBUILD, $urandom_range(0, 31), 0, '0, '0);
			send_command(OP_REFRESH, $urandom_range(0, 31), $urandom_range(0, 31), '0, '0);
			send_command(OP_READ, $urandom_range(0, 31), 0, '0, '0);
		end
	endtask

	task automatic test_backpressure();
		wait_idle();
		hold_request = 1'b1;
		burst_left = 40;
		for (int n = 0; n < 12; n++)
			send_command(OP_ADD, $urandom_range(0, 31), $urandom_range(0, 31), '0, '0);
		wait_idle();
		stall_mode = 0;
		for (int n = 0; n < 20; n++) random_command();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.operation = OP_READ;
		req.first_vertex = '0;
		req.second_vertex = '0;
		req.row_adjacency = '0;
		req.row_mask = '0;
		mismatches = 0;
		idle_cycles = 0;
		hold_left = 0;
		hold_request = 1'b0;
		cycle_no = 0;
		stall_mode = 0;
		burst_left = 5;
		prefix_shadow = PREFIX_RESET;
		for (int i = 0; i < NV; i++) begin
			adj_rows[i] = '0;
			cand_rows[i] = '1;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_prefix_extremes();
		stall_mode = 1;
		test_random_mix();
		stall_mode = 2;
		test_sparse_search();
		test_backpressure();
		set_prefix($urandom_range(11, 31));
		stall_mode = 1;
		test_random_mix();
		set_prefix(6'd10);

		wait_idle();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASS triangle_square_free_edge_mask_top");
		end else begin
			$display("FAIL triangle_square_free_edge_mask_top");
		end
		$finish;
	end

endmodule
